// ===== rtl/core/bmp_row_pixel_unpacker_assert.svh =====
// assertion macros for the bmp row pixel unpacker checkers
`ifndef BMP_ROW_PIXEL_UNPACKER_ASSERT_SVH
`define BMP_ROW_PIXEL_UNPACKER_ASSERT_SVH

// property sampled on the rising clock, switched off while reset is low
`define BRPU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property sampled on the rising clock, reset cycles included
`define BRPU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bmp_rpu_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and scaling tables of the bmp row pixel unpacker
package bmp_rpu_pkg;

    localparam int CNT_W      = 13;
    localparam int COORD_W    = 12;
    localparam int LINE_W     = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // operation codes of an input transaction
    localparam logic OP_PAL_WRITE  = 1'b0;
    localparam logic OP_PIXEL_DATA = 1'b1;

    // pixel format codes
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_16BPP = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_32BPP = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK    = 3'd6;

    localparam logic [15:0] RED_MASK_RST   = 16'h7C00;
    localparam logic [15:0] GREEN_MASK_RST = 16'h03E0;
    localparam logic [15:0] BLUE_MASK_RST  = 16'h001F;
    localparam logic [15:0] GREEN_MASK_565 = 16'h07E0;

    // how a pixel gets its color
    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_DIRECT  = 2'd1;
    localparam logic [1:0] KIND_MASKED  = 2'd2;

    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [23:0] rgb;
    } t_pal_wr;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         idx;
        logic [23:0]        direct;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_of_run;
        logic               image_done;
    } t_pix;

    typedef struct packed {
        logic [2:0]        fmt;
        logic              fmt_ok;
        logic              top_down;
        logic [CNT_W-1:0]  width;
        logic [CNT_W-1:0]  width_m1;
        logic [CNT_W-1:0]  height_m1;
        logic [LINE_W-1:0] line_bytes;
    } t_geom;

    typedef struct packed {
        logic [15:0] red_mask;
        logic [15:0] green_mask;
        logic [15:0] blue_mask;
        logic [3:0]  red_sh;
        logic [3:0]  green_sh;
        logic [3:0]  blue_sh;
        logic        green6;
    } t_mask_cfg;

    typedef logic [31:0][7:0] t_scale5;
    typedef logic [63:0][7:0] t_scale6;

    function automatic t_scale5 build_scale5();
        t_scale5 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'((i * 255) / 31);
        end
        return t;
    endfunction

    function automatic t_scale6 build_scale6();
        t_scale6 t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'((i * 255) / 63);
        end
        return t;
    endfunction

    localparam t_scale5 SCALE5 = build_scale5();
    localparam t_scale6 SCALE6 = build_scale6();

    // position of the lowest set bit, 0 for an empty mask
    function automatic logic [3:0] lsb_pos(input logic [15:0] m);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (m[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/bmp_rpu_expand.sv =====
`timescale 1ns / 1ps
// input stage: holds one transaction and issues palette writes and pixels
module bmp_rpu_expand
    import bmp_rpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_palette_index,
    input  logic [7:0]  i_palette_red,
    input  logic [7:0]  i_palette_green,
    input  logic [7:0]  i_palette_blue,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    input  t_geom       i_geom,
    input  logic        i_s2_free,
    output logic        o_pix_valid,
    output t_pix        o_pix,
    output t_pal_wr     o_pal_wr
);

    logic              r_xv;
    logic              r_op;
    logic [7:0]        r_pidx;
    logic [23:0]       r_prgb;
    logic [7:0]        r_byte;
    logic [2:0]        r_sub;
    logic [CNT_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_row;
    logic [LINE_W-1:0] r_rbc;
    logic [23:0]       r_gather;
    logic [1:0]        r_bip;

    logic [2:0]        n_sub;
    logic [CNT_W-1:0]  n_col;
    logic [CNT_W-1:0]  n_row;
    logic [LINE_W-1:0] n_rbc;
    logic [23:0]       n_gather;
    logic [1:0]        n_bip;

    logic              in_row;
    logic              data_ok;
    logic              gathering;
    logic              complete;
    logic              emit;
    logic              last_pix;
    logic              fin;
    logic              fire;
    logic              row_end;
    logic              accept;
    logic [2:0]        bip_inc;
    logic [2:0]        need;
    logic [23:0]       fg;
    logic [7:0]        idx;
    logic [1:0]        kind;
    logic [23:0]       direct;
    logic [LINE_W:0]   rbc_inc;
    logic [CNT_W-1:0]  y;

    always_comb begin
        in_row    = r_col < i_geom.width;
        data_ok   = r_xv && (r_op == OP_PIXEL_DATA) && i_geom.fmt_ok;
        gathering = (i_geom.fmt == FMT_16BPP) || (i_geom.fmt == FMT_24BPP)
                    || (i_geom.fmt == FMT_32BPP);
        bip_inc   = {1'b0, r_bip} + 3'd1;
        fg        = r_gather;
        // the fourth byte of a 32 bpp pixel is dropped
        if (r_bip != 2'd3) begin
            fg = r_gather | (24'(r_byte) << {r_bip, 3'b000});
        end
        case (i_geom.fmt)
            FMT_16BPP: need = 3'd2;
            FMT_24BPP: need = 3'd3;
            default:   need = 3'd4;
        endcase
        complete = bip_inc >= need;

        emit     = 1'b0;
        last_pix = 1'b1;
        idx      = r_byte;
        kind     = KIND_PALETTE;
        direct   = fg;
        case (i_geom.fmt)
            FMT_1BPP: begin
                emit     = in_row;
                idx      = {7'd0, r_byte[~r_sub]};
                last_pix = (r_sub == 3'd7) || (r_col == i_geom.width_m1);
            end
            FMT_4BPP: begin
                emit     = in_row;
                idx      = r_sub[0] ? {4'd0, r_byte[3:0]} : {4'd0, r_byte[7:4]};
                last_pix = r_sub[0] || (r_col == i_geom.width_m1);
            end
            FMT_8BPP: begin
                emit = in_row;
            end
            FMT_16BPP: begin
                emit   = in_row && complete;
                kind   = KIND_MASKED;
                direct = {8'd0, fg[15:0]};
            end
            default: begin
                emit = in_row && complete;
                kind = KIND_DIRECT;
            end
        endcase
        emit = emit && data_ok;
        fin  = !emit || last_pix;
        fire = r_xv && (!emit || i_s2_free);

        rbc_inc = {1'b0, r_rbc} + 1'b1;
        row_end = rbc_inc >= {1'b0, i_geom.line_bytes};
        y       = i_geom.top_down ? r_row : (i_geom.height_m1 - r_row);

        n_sub    = r_sub;
        n_col    = r_col;
        n_row    = r_row;
        n_rbc    = r_rbc;
        n_gather = r_gather;
        n_bip    = r_bip;
        if (fire && data_ok) begin
            if (emit) begin
                n_col = r_col + 1'b1;
            end
            n_sub = fin ? 3'd0 : (r_sub + 3'd1);
            if (fin) begin
                if (in_row && gathering) begin
                    if (complete) begin
                        n_gather = 24'd0;
                        n_bip    = 2'd0;
                    end else begin
                        n_gather = fg;
                        n_bip    = bip_inc[1:0];
                    end
                end
                // padding done: next row
                if (row_end) begin
                    n_rbc    = '0;
                    n_col    = '0;
                    n_gather = 24'd0;
                    n_bip    = 2'd0;
                    n_row    = (r_row == i_geom.height_m1) ? '0 : (r_row + 1'b1);
                end else begin
                    n_rbc = rbc_inc[LINE_W-1:0];
                end
            end
        end
    end

    assign o_stall = !i_rst_n || (r_xv && !(fire && fin));
    assign accept  = i_valid && !o_stall;

    assign o_pix_valid        = fire && emit;
    assign o_pix.kind         = kind;
    assign o_pix.idx          = idx;
    assign o_pix.direct       = direct;
    assign o_pix.column       = r_col[COORD_W-1:0];
    assign o_pix.row          = y[COORD_W-1:0];
    assign o_pix.last_of_run  = last_pix;
    assign o_pix.image_done   = (r_col == i_geom.width_m1) && (r_row == i_geom.height_m1);

    assign o_pal_wr.en  = r_xv && (r_op == OP_PAL_WRITE);
    assign o_pal_wr.idx = r_pidx;
    assign o_pal_wr.rgb = r_prgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv     <= 1'b0;
            r_sub    <= 3'd0;
            r_col    <= '0;
            r_row    <= '0;
            r_rbc    <= '0;
            r_gather <= 24'd0;
            r_bip    <= 2'd0;
        end else begin
            if (i_restart) begin
                r_sub    <= 3'd0;
                r_col    <= '0;
                r_row    <= '0;
                r_rbc    <= '0;
                r_gather <= 24'd0;
                r_bip    <= 2'd0;
            end else begin
                r_sub    <= n_sub;
                r_col    <= n_col;
                r_row    <= n_row;
                r_rbc    <= n_rbc;
                r_gather <= n_gather;
                r_bip    <= n_bip;
            end
            if (accept) begin
                r_xv <= 1'b1;
            end else if (fire && fin) begin
                r_xv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_pidx <= i_palette_index;
            r_prgb <= {i_palette_red, i_palette_green, i_palette_blue};
            r_byte <= i_data_byte;
        end
    end

endmodule

// ===== rtl/core/bmp_rpu_palette.sv =====
`timescale 1ns / 1ps
// palette memory with its registered read stage
module bmp_rpu_palette
    import bmp_rpu_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pal_wr i_pal_wr,
    input  logic    i_pix_valid,
    input  t_pix    i_pix,
    input  logic    i_take_free,
    output logic    o_s2_free,
    output logic    o_pix_valid,
    output t_pix    o_pix,
    output logic    o_black,
    output logic [23:0] o_pal_rgb
);

    localparam int         PAW    = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

    logic [23:0] r_mem [PALETTE_DEPTH];
    logic [23:0] r_rd_data;
    logic        r_v2;
    t_pix        r_pix;
    logic        r_black;

    logic wr_hit;
    logic rd_en;

    // entries at or above the depth are never written and read as black
    assign wr_hit    = i_pal_wr.en && ({1'b0, i_pal_wr.idx} < DEPTH9);
    assign rd_en     = i_pix_valid && (i_pix.kind == KIND_PALETTE);
    assign o_s2_free = !r_v2 || i_take_free;

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[i_pal_wr.idx[PAW-1:0]] <= i_pal_wr.rgb;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[i_pix.idx[PAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_pix_valid) begin
            r_v2 <= 1'b1;
        end else if (i_take_free) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix_valid) begin
            r_pix   <= i_pix;
            r_black <= !({1'b0, i_pix.idx} < DEPTH9);
        end
    end

    assign o_pix_valid = r_v2;
    assign o_pix       = r_pix;
    assign o_black     = r_black;
    assign o_pal_rgb   = r_rd_data;

endmodule

// ===== rtl/core/bmp_rpu_color.sv =====
`timescale 1ns / 1ps
// color select, 16 bpp channel scaling and the output register
module bmp_rpu_color
    import bmp_rpu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pix_valid,
    input  t_pix               i_pix,
    input  logic               i_black,
    input  logic [23:0]        i_pal_rgb,
    input  t_mask_cfg          i_mask,
    output logic               o_take_free,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [COORD_W-1:0] o_column,
    output logic [COORD_W-1:0] o_row,
    output logic               o_last_of_run,
    output logic               o_image_done
);

    logic               r_ov;
    logic [23:0]        r_rgb;
    logic [COORD_W-1:0] r_column;
    logic [COORD_W-1:0] r_row;
    logic               r_last;
    logic               r_done;

    logic [15:0] p;
    logic [15:0] rx;
    logic [15:0] gx;
    logic [15:0] bx;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [23:0] rgb;
    logic        take_free;

    function automatic logic [7:0] scale5(input logic [15:0] x);
        return (|x[15:5]) ? 8'd255 : SCALE5[x[4:0]];
    endfunction

    function automatic logic [7:0] scale6(input logic [15:0] x);
        return (|x[15:6]) ? 8'd255 : SCALE6[x[5:0]];
    endfunction

    always_comb begin
        p  = i_pix.direct[15:0];
        rx = (p & i_mask.red_mask) >> i_mask.red_sh;
        gx = (p & i_mask.green_mask) >> i_mask.green_sh;
        bx = (p & i_mask.blue_mask) >> i_mask.blue_sh;
        r8 = scale5(rx);
        g8 = i_mask.green6 ? scale6(gx) : scale5(gx);
        b8 = scale5(bx);
        case (i_pix.kind)
            KIND_PALETTE: rgb = i_black ? 24'd0 : i_pal_rgb;
            KIND_DIRECT:  rgb = i_pix.direct;
            KIND_MASKED:  rgb = {r8, g8, b8};
            default:      rgb = 24'd0;
        endcase
    end

    assign take_free   = !r_ov || !i_stall;
    assign o_take_free = take_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (take_free) begin
            r_ov <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_free && i_pix_valid) begin
            r_rgb    <= rgb;
            r_column <= i_pix.column;
            r_row    <= i_pix.row;
            r_last   <= i_pix.last_of_run;
            r_done   <= i_pix.image_done;
        end
    end

    assign o_valid       = r_ov;
    assign o_red         = r_rgb[23:16];
    assign o_green       = r_rgb[15:8];
    assign o_blue        = r_rgb[7:0];
    assign o_column      = r_column;
    assign o_row         = r_row;
    assign o_last_of_run = r_last;
    assign o_image_done  = r_done;

endmodule

// ===== rtl/core/bmp_row_pixel_unpacker.sv =====
`timescale 1ns / 1ps
// top level of the bmp row pixel unpacker: config registers and the three stages
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall       operation, palette write, data byte
//   output    out        o_valid / i_stall       rgb, column, row, last_of_run, image_done
//   config    in         i_cfg_wr_en             i_cfg_index, i_cfg_wdata
//
// palette writes and 8, 16, 24 and 32 bpp bytes can be taken back to back; a 4 bpp
// byte inside the row issues 2 pixels and a 1 bpp byte up to 8, one pixel per
// cycle through the single palette read port while stage 2 is free to take it
// a pixel passes from stage 1 through the palette read register to the output register
// reset: config goes to 16 bpp 5-5-5, one by one pixel, bottom-up; pipeline empties;
// the palette keeps no reset value and needs no clearing pass
// o_stall is high in reset and while the held transaction still has pixels to issue
module bmp_row_pixel_unpacker
    import bmp_rpu_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [7:0]            i_palette_index,
    input  logic [7:0]            i_palette_red,
    input  logic [7:0]            i_palette_green,
    input  logic [7:0]            i_palette_blue,
    input  logic [7:0]            i_data_byte,
    // pixel transactions
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [COORD_W-1:0]    o_column,
    output logic [COORD_W-1:0]    o_row,
    output logic                  o_last_of_run,
    output logic                  o_image_done,
    // config writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // config registers
    logic [2:0]       r_pixel_format;
    logic [CNT_W-1:0] r_image_width;
    logic [CNT_W-1:0] r_image_height;
    logic             r_top_down;
    logic [15:0]      r_red_mask;
    logic [15:0]      r_green_mask;
    logic [15:0]      r_blue_mask;

    // values derived from config, held in registers behind it
    t_geom     r_geom;
    t_geom     n_geom;
    t_mask_cfg r_mask;
    t_mask_cfg n_mask;

    logic             cfg_known;
    logic             restart;
    logic [CNT_W-1:0] eff_w;
    logic [CNT_W-1:0] eff_h;
    logic [18:0]      line_bits;
    logic [18:0]      line_sum;

    // stage links
    logic    s2_free;
    logic    take_free;
    logic    x_pix_valid;
    t_pix    x_pix;
    t_pal_wr pal_wr;
    logic    s2_pix_valid;
    t_pix    s2_pix;
    logic    s2_black;
    logic [23:0] s2_pal_rgb;

    // any write to a known register restarts the image
    always_comb begin
        case (i_cfg_index)
            CFG_PIXEL_FORMAT, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_TOP_DOWN,
            CFG_RED_MASK, CFG_GREEN_MASK, CFG_BLUE_MASK: cfg_known = 1'b1;
            default:                                      cfg_known = 1'b0;
        endcase
    end

    assign restart = i_cfg_wr_en && cfg_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_16BPP;
            r_image_width  <= CNT_W'(1);
            r_image_height <= CNT_W'(1);
            r_top_down     <= 1'b0;
            r_red_mask     <= RED_MASK_RST;
            r_green_mask   <= GREEN_MASK_RST;
            r_blue_mask    <= BLUE_MASK_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PIXEL_FORMAT: r_pixel_format <= i_cfg_wdata[2:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[CNT_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata[CNT_W-1:0];
                CFG_TOP_DOWN:     r_top_down     <= i_cfg_wdata[0];
                CFG_RED_MASK:     r_red_mask     <= i_cfg_wdata[15:0];
                CFG_GREEN_MASK:   r_green_mask   <= i_cfg_wdata[15:0];
                CFG_BLUE_MASK:    r_blue_mask    <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // geometry: clamped width and height, padded row length in bytes
    always_comb begin
        if (r_image_width == '0) begin
            eff_w = CNT_W'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            eff_w = CNT_W'(MAX_WIDTH);
        end else begin
            eff_w = r_image_width;
        end
        if (r_image_height == '0) begin
            eff_h = CNT_W'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            eff_h = CNT_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_image_height;
        end

        case (r_pixel_format)
            FMT_1BPP:  line_bits = 19'(eff_w);
            FMT_4BPP:  line_bits = 19'(eff_w) << 2;
            FMT_8BPP:  line_bits = 19'(eff_w) << 3;
            FMT_16BPP: line_bits = 19'(eff_w) << 4;
            FMT_24BPP: line_bits = (19'(eff_w) << 4) + (19'(eff_w) << 3);
            FMT_32BPP: line_bits = 19'(eff_w) << 5;
            default:   line_bits = 19'd0;
        endcase
        // round up to whole 32-bit words
        line_sum = line_bits + 19'd31;

        n_geom.fmt        = r_pixel_format;
        n_geom.fmt_ok     = r_pixel_format <= FMT_32BPP;
        n_geom.top_down   = r_top_down;
        n_geom.width      = eff_w;
        n_geom.width_m1   = eff_w - 1'b1;
        n_geom.height_m1  = eff_h - 1'b1;
        n_geom.line_bytes = LINE_W'({line_sum[17:5], 2'b00});

        n_mask.red_mask   = r_red_mask;
        n_mask.green_mask = r_green_mask;
        n_mask.blue_mask  = r_blue_mask;
        n_mask.red_sh     = lsb_pos(r_red_mask);
        n_mask.green_sh   = lsb_pos(r_green_mask);
        n_mask.blue_sh    = lsb_pos(r_blue_mask);
        n_mask.green6     = r_green_mask == GREEN_MASK_565;
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
        r_mask <= n_mask;
    end

    // stage 1: holds the transaction, counts columns, rows and row bytes
    bmp_rpu_expand u_expand (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_palette_index (i_palette_index),
        .i_palette_red   (i_palette_red),
        .i_palette_green (i_palette_green),
        .i_palette_blue  (i_palette_blue),
        .i_data_byte     (i_data_byte),
        .i_restart       (restart),
        .i_geom          (r_geom),
        .i_s2_free       (s2_free),
        .o_pix_valid     (x_pix_valid),
        .o_pix           (x_pix),
        .o_pal_wr        (pal_wr)
    );

    // stage 2: palette read; writes and reads leave stage 1 in order, one per
    // cycle, so a read never meets a write to the same entry
    bmp_rpu_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pal_wr    (pal_wr),
        .i_pix_valid (x_pix_valid),
        .i_pix       (x_pix),
        .i_take_free (take_free),
        .o_s2_free   (s2_free),
        .o_pix_valid (s2_pix_valid),
        .o_pix       (s2_pix),
        .o_black     (s2_black),
        .o_pal_rgb   (s2_pal_rgb)
    );

    // stage 3: color select and output register
    bmp_rpu_color u_color (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (s2_pix_valid),
        .i_pix         (s2_pix),
        .i_black       (s2_black),
        .i_pal_rgb     (s2_pal_rgb),
        .i_mask        (r_mask),
        .o_take_free   (take_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_last_of_run (o_last_of_run),
        .o_image_done  (o_image_done)
    );

endmodule

// ===== rtl/core/bmp_rpu_chk.sv =====
`timescale 1ns / 1ps
// port checker of the bmp row pixel unpacker and its bind
`include "bmp_row_pixel_unpacker_assert.svh"
module bmp_rpu_chk
    import bmp_rpu_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [7:0]         o_red,
    input logic [7:0]         o_green,
    input logic [7:0]         o_blue,
    input logic [COORD_W-1:0] o_column,
    input logic [COORD_W-1:0] o_row,
    input logic               o_last_of_run,
    input logic               o_image_done
);

    `BRPU_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "pixel dropped while stalled")
    `BRPU_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable({o_red, o_green, o_blue, o_column, o_row, o_last_of_run, o_image_done}), "stalled pixel changed")
    `BRPU_ASSERT(a_done_ends_run, i_clk, i_rst_n, o_valid && o_image_done |-> o_last_of_run, "image end not last of run")
    `BRPU_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `BRPU_ASSERT_ALWAYS(a_rst_stall, i_clk, !i_rst_n |-> o_stall, "input taken in reset")

endmodule

bind bmp_row_pixel_unpacker bmp_rpu_chk u_chk (.*);

// ===== verif/tb_bmp_row_pixel_unpacker.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the bmp row pixel unpacker: directed script, then random images
module tb_bmp_row_pixel_unpacker;
    import bmp_rpu_pkg::*;

    localparam int DIM_MAX       = 4096;  // default MAX_WIDTH / MAX_HEIGHT of the block
    localparam int ITEM_TARGET   = 410;
    localparam int SETTLE_CYCLES = 12;    // lets the pipe empty after the last owed pixel
    localparam int QUIET_LIMIT   = 2000;
    localparam int SHOWN_ERRORS  = 10;

    // one input transaction
    typedef struct packed {
        logic       op;
        logic [7:0] pal_idx;
        logic [7:0] pal_r;
        logic [7:0] pal_g;
        logic [7:0] pal_b;
        logic [7:0] data;
    } item_t;

    // one pixel transaction
    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_of_run;
        logic               image_done;
    } pixel_t;

    // one row of the directed script: a register write or a transaction
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        item_t                 it;
        bit                    typed;
        pixel_t                px;
    } step_t;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic                  i_operation = OP_PAL_WRITE;
    logic [7:0]            i_palette_index = '0;
    logic [7:0]            i_palette_red   = '0;
    logic [7:0]            i_palette_green = '0;
    logic [7:0]            i_palette_blue  = '0;
    logic [7:0]            i_data_byte     = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic [COORD_W-1:0]    o_column;
    logic [COORD_W-1:0]    o_row;
    logic                  o_last_of_run;
    logic                  o_image_done;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    bmp_row_pixel_unpacker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_palette_index (i_palette_index),
        .i_palette_red   (i_palette_red),
        .i_palette_green (i_palette_green),
        .i_palette_blue  (i_palette_blue),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_column        (o_column),
        .o_row           (o_row),
        .o_last_of_run   (o_last_of_run),
        .o_image_done    (o_image_done),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------
    // decoder state mirrored by the testbench
    // ---------------------------------------------------------------------------
    logic [23:0]           pal_mem [256];
    bit                    pal_known [256];
    logic [2:0]            fmt_reg;
    logic [12:0]           width_reg;
    logic [12:0]           height_reg;
    logic                  td_reg;
    logic [15:0]           red_mask_reg;
    logic [15:0]           green_mask_reg;
    logic [15:0]           blue_mask_reg;
    logic [23:0]           gather;
    int                    gather_n;
    int                    col_cnt;
    int                    row_cnt;
    int                    line_pos;

    // pixels decoded from the latest transaction, last one flagged at the end
    pixel_t                decoded [8];
    int                    decoded_n;

    // pixels still owed by the block, oldest first
    pixel_t                pending_pixels [$];

    step_t                 script [$];

    bit                    tx_idle;
    bit                    rx_idle;
    int                    hold_cycles;
    int                    errors;
    int                    items_sent;
    int                    pal_writes;
    int                    data_bytes;
    int                    cfg_writes;
    int                    pixels_checked;

    // out-of-range sizes act as the nearest legal one
    function automatic int dim_of(logic [12:0] v);
        if (v == 13'd0) begin
            return 1;
        end
        if (int'(v) > DIM_MAX) begin
            return DIM_MAX;
        end
        return int'(v);
    endfunction

    function automatic int bpp_of(logic [2:0] f);
        case (f)
            FMT_1BPP:  return 1;
            FMT_4BPP:  return 4;
            FMT_8BPP:  return 8;
            FMT_16BPP: return 16;
            FMT_24BPP: return 24;
            default:   return 32;
        endcase
    endfunction

    // row length in bytes, padded to whole 32-bit words
    function automatic int row_bytes();
        return ((dim_of(width_reg) * bpp_of(fmt_reg) + 31) / 32) * 4;
    endfunction

    // masked channel shifted down by the mask's lowest set bit, scaled and clamped
    function automatic logic [7:0] scale_chan(logic [15:0] p, logic [15:0] m, int top);
        int sh;
        int v;
        if (m == 16'd0) begin
            return 8'd0;
        end
        sh = 0;
        while (!m[sh] && sh < 15) begin
            sh++;
        end
        v = int'((p & m) >> sh) * 255 / top;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic void add_pixel(logic [23:0] rgb);
        int w;
        int h;
        int y;
        w = dim_of(width_reg);
        h = dim_of(height_reg);
        y = td_reg ? row_cnt : (h - 1 - row_cnt);
        decoded[decoded_n].red         = rgb[23:16];
        decoded[decoded_n].green       = rgb[15:8];
        decoded[decoded_n].blue        = rgb[7:0];
        decoded[decoded_n].column      = COORD_W'(col_cnt);
        decoded[decoded_n].row         = COORD_W'(y);
        decoded[decoded_n].last_of_run = 1'b0;
        decoded[decoded_n].image_done  = (col_cnt == w - 1) && (row_cnt == h - 1);
        decoded_n++;
        col_cnt++;
    endfunction

    function automatic void clear_counters();
        gather   = '0;
        gather_n = 0;
        col_cnt  = 0;
        row_cnt  = 0;
        line_pos = 0;
    endfunction

    function automatic void restore_defaults();
        for (int k = 0; k < 256; k++) begin
            pal_mem[k]   = '0;
            pal_known[k] = 1'b0;
        end
        fmt_reg        = FMT_16BPP;
        width_reg      = 13'd1;
        height_reg     = 13'd1;
        td_reg         = 1'b0;
        red_mask_reg   = RED_MASK_RST;
        green_mask_reg = GREEN_MASK_RST;
        blue_mask_reg  = BLUE_MASK_RST;
        clear_counters();
    endfunction

    // any register write starts a new image; the palette is kept
    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_PIXEL_FORMAT: fmt_reg        = v[2:0];
            CFG_IMAGE_WIDTH:  width_reg      = v[12:0];
            CFG_IMAGE_HEIGHT: height_reg     = v[12:0];
            CFG_TOP_DOWN:     td_reg         = v[0];
            CFG_RED_MASK:     red_mask_reg   = v;
            CFG_GREEN_MASK:   green_mask_reg = v;
            CFG_BLUE_MASK:    blue_mask_reg  = v;
            default:          return;
        endcase
        clear_counters();
    endfunction

    // pixels that one input transaction produces, left in decoded[]
    function automatic void decode_transaction(item_t it);
        int          w;
        int          gtop;
        logic [7:0]  m;
        logic [15:0] p;
        decoded_n = 0;
        if (it.op == OP_PAL_WRITE) begin
            pal_mem[it.pal_idx]   = {it.pal_r, it.pal_g, it.pal_b};
            pal_known[it.pal_idx] = 1'b1;
            return;
        end
        // unknown formats drop the byte and keep every counter
        if (fmt_reg > FMT_32BPP) begin
            return;
        end
        w = dim_of(width_reg);
        if (col_cnt < w) begin
            case (fmt_reg)
                FMT_1BPP: begin
                    m = 8'h80;
                    while (m != 8'd0 && col_cnt < w) begin
                        add_pixel(pal_mem[((it.data & m) != 8'd0) ? 8'd1 : 8'd0]);
                        m = m >> 1;
                    end
                end
                FMT_4BPP: begin
                    add_pixel(pal_mem[{4'd0, it.data[7:4]}]);
                    if (col_cnt < w) begin
                        add_pixel(pal_mem[{4'd0, it.data[3:0]}]);
                    end
                end
                FMT_8BPP: begin
                    add_pixel(pal_mem[it.data]);
                end
                default: begin
                    // bytes arrive b, g, r; the fourth of 32 bpp is dropped
                    if (gather_n < 3) begin
                        gather = gather | (24'(it.data) << (8 * gather_n));
                    end
                    gather_n++;
                    if (gather_n >= bpp_of(fmt_reg) / 8) begin
                        if (fmt_reg == FMT_16BPP) begin
                            p    = gather[15:0];
                            gtop = (green_mask_reg == GREEN_MASK_565) ? 63 : 31;
                            add_pixel({scale_chan(p, red_mask_reg, 31),
                                       scale_chan(p, green_mask_reg, gtop),
                                       scale_chan(p, blue_mask_reg, 31)});
                        end else begin
                            add_pixel(gather);
                        end
                        gather   = '0;
                        gather_n = 0;
                    end
                end
            endcase
        end
        // padding bytes only move the row position
        line_pos++;
        if (line_pos >= row_bytes()) begin
            line_pos = 0;
            col_cnt  = 0;
            gather   = '0;
            gather_n = 0;
            row_cnt++;
            if (row_cnt >= dim_of(height_reg)) begin
                row_cnt = 0;
            end
        end
        if (decoded_n > 0) begin
            decoded[decoded_n - 1].last_of_run = 1'b1;
        end
    endfunction

    // first palette entry a data byte would read before it was ever written, else -1
    function automatic int missing_entry(logic [7:0] b);
        int w;
        int n;
        w = dim_of(width_reg);
        if (col_cnt >= w) begin
            return -1;
        end
        case (fmt_reg)
            FMT_1BPP: begin
                n = (w - col_cnt < 8) ? (w - col_cnt) : 8;
                for (int k = 0; k < n; k++) begin
                    if (!pal_known[{7'd0, b[7 - k]}]) begin
                        return int'(b[7 - k]);
                    end
                end
            end
            FMT_4BPP: begin
                if (!pal_known[{4'd0, b[7:4]}]) begin
                    return int'(b[7:4]);
                end
                if (col_cnt + 1 < w && !pal_known[{4'd0, b[3:0]}]) begin
                    return int'(b[3:0]);
                end
            end
            FMT_8BPP: begin
                if (!pal_known[b]) begin
                    return int'(b);
                end
            end
            default: ;
        endcase
        return -1;
    endfunction

    function automatic item_t random_item(logic op);
        item_t it;
        it.op      = op;
        it.pal_idx = 8'($urandom);
        it.pal_r   = 8'($urandom);
        it.pal_g   = 8'($urandom);
        it.pal_b   = 8'($urandom);
        it.data    = 8'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_mask(logic [15:0] usual);
        case ($urandom_range(0, 5))
            0, 1, 2: return usual;
            3, 4:    return 16'($urandom);
            default: return 16'd0;
        endcase
    endfunction

    // ---------------------------------------------------------------------------
    // directed script rows
    // ---------------------------------------------------------------------------
    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        step_t s;
        s          = '{default: '0};
        s.is_cfg   = 1'b1;
        s.cfg_idx  = idx;
        s.cfg_data = v;
        script.push_back(s);
    endfunction

    function automatic void add_pal(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b);
        step_t s;
        s            = '{default: '0};
        s.it         = random_item(OP_PAL_WRITE);
        s.it.pal_idx = idx;
        s.it.pal_r   = r;
        s.it.pal_g   = g;
        s.it.pal_b   = b;
        script.push_back(s);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        step_t s;
        s         = '{default: '0};
        s.it      = random_item(OP_PIXEL_DATA);
        s.it.data = b;
        script.push_back(s);
    endfunction

    // byte whose single pixel is known by inspection
    function automatic void add_byte_px(logic [7:0] b, logic [23:0] rgb, int col, int y,
                                        logic done);
        step_t s;
        s                  = '{default: '0};
        s.it               = random_item(OP_PIXEL_DATA);
        s.it.data          = b;
        s.typed            = 1'b1;
        s.px.red           = rgb[23:16];
        s.px.green         = rgb[15:8];
        s.px.blue          = rgb[7:0];
        s.px.column        = COORD_W'(col);
        s.px.row           = COORD_W'(y);
        s.px.last_of_run   = 1'b1;
        s.px.image_done    = done;
        script.push_back(s);
    endfunction

    // ---------------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------------

    // valid stays high after a transaction; whoever goes next decides whether it drops
    task automatic send_item(item_t it, bit typed, pixel_t typed_px);
        int gap;
        bit ignored;
        gap = tx_idle ? int'($urandom_range(0, 8)) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= it.op;
        i_palette_index <= it.pal_idx;
        i_palette_red   <= it.pal_r;
        i_palette_green <= it.pal_g;
        i_palette_blue  <= it.pal_b;
        i_data_byte     <= it.data;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        ignored = (it.op == OP_PIXEL_DATA) && (fmt_reg > FMT_32BPP);
        decode_transaction(it);
        if (typed) begin
            pending_pixels.push_back(typed_px);
        end else begin
            for (int k = 0; k < decoded_n; k++) begin
                pending_pixels.push_back(decoded[k]);
            end
        end
        if (!ignored) begin
            items_sent++;
        end
        if (it.op == OP_PAL_WRITE) begin
            pal_writes++;
        end else begin
            data_bytes++;
        end
    endtask

    task automatic send_palette(logic [7:0] idx);
        item_t it;
        pixel_t none;
        none       = '0;
        it         = random_item(OP_PAL_WRITE);
        it.pal_idx = idx;
        send_item(it, 1'b0, none);
    endtask

    // hold off the sender until every owed pixel is out, optionally let the pipe empty
    task automatic drain_outputs(bit settle);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        if (settle) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    // write enable stays high across a burst; the caller lowers it after the last one
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        apply_cfg(idx, v);
        cfg_writes++;
    endtask

    task automatic run_script();
        int i;
        i = 0;
        while (i < script.size()) begin
            if (script[i].is_cfg) begin
                drain_outputs(1'b1);
                while (i < script.size() && script[i].is_cfg) begin
                    cfg_write(script[i].cfg_idx, script[i].cfg_data);
                    i++;
                end
                i_cfg_wr_en <= 1'b0;
            end else begin
                send_item(script[i].it, script[i].typed, script[i].px);
                i++;
            end
        end
    endtask

    // one random image setup per phase, then a stream of bytes for it
    task automatic run_random_phase();
        int         full;
        int         n;
        int         idx;
        int         mode;
        item_t      it;
        pixel_t     none;
        none = '0;
        drain_outputs(1'b1);
        mode    = $urandom_range(0, 3);
        tx_idle = mode[0];
        rx_idle = mode[1];

        cfg_write(CFG_PIXEL_FORMAT, ($urandom_range(0, 11) == 0) ?
                  16'($urandom_range(6, 7)) : 16'($urandom_range(0, 5)));
        if ($urandom_range(0, 3) != 0) begin
            cfg_write(CFG_IMAGE_WIDTH, ($urandom_range(0, 9) == 0) ?
                      16'($urandom_range(0, 8191)) : 16'($urandom_range(1, 12)));
        end
        if ($urandom_range(0, 3) != 0) begin
            cfg_write(CFG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ?
                      16'($urandom_range(0, 8191)) : 16'($urandom_range(1, 3)));
        end
        if ($urandom_range(0, 3) != 0) begin
            cfg_write(CFG_TOP_DOWN, 16'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 3) != 0) begin
            cfg_write(CFG_RED_MASK, pick_mask(RED_MASK_RST));
        end
        if ($urandom_range(0, 3) != 0) begin
            cfg_write(CFG_GREEN_MASK, pick_mask($urandom_range(0, 1) ?
                                                GREEN_MASK_565 : GREEN_MASK_RST));
        end
        if ($urandom_range(0, 3) != 0) begin
            cfg_write(CFG_BLUE_MASK, pick_mask(BLUE_MASK_RST));
        end
        i_cfg_wr_en <= 1'b0;

        // mostly whole images plus a few bytes into the next one, some cut short
        full = row_bytes() * dim_of(height_reg);
        if (fmt_reg > FMT_32BPP) begin
            n = $urandom_range(2, 6);
        end else if (full <= 60) begin
            n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, full)) :
                full + int'($urandom_range(0, 3));
        end else begin
            n = $urandom_range(8, 48);
        end

        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_palette(8'($urandom));
            end
            if ($urandom_range(0, 39) == 0) begin
                drain_outputs(1'b0);
            end
            it  = random_item(OP_PIXEL_DATA);
            // load any palette entry this byte would read before it goes in
            idx = missing_entry(it.data);
            while (idx >= 0) begin
                send_palette(8'(idx));
                idx = missing_entry(it.data);
            end
            send_item(it, 1'b0, none);
        end
    endtask

    // ---------------------------------------------------------------------------
    // output side: random stall after each pixel, compare against the oldest owed
    // ---------------------------------------------------------------------------
    pixel_t seen_px;
    pixel_t want_px;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_px.red         = o_red;
            seen_px.green       = o_green;
            seen_px.blue        = o_blue;
            seen_px.column      = o_column;
            seen_px.row         = o_row;
            seen_px.last_of_run = o_last_of_run;
            seen_px.image_done  = o_image_done;
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS) begin
                    $display("unexpected pixel: rgb %02h%02h%02h col %0d row %0d",
                             seen_px.red, seen_px.green, seen_px.blue,
                             seen_px.column, seen_px.row);
                end
            end else begin
                want_px = pending_pixels.pop_front();
                if (seen_px.red !== want_px.red || seen_px.green !== want_px.green ||
                    seen_px.blue !== want_px.blue || seen_px.column !== want_px.column ||
                    seen_px.row !== want_px.row ||
                    seen_px.last_of_run !== want_px.last_of_run ||
                    seen_px.image_done !== want_px.image_done) begin
                    errors++;
                    if (errors <= SHOWN_ERRORS) begin
                        $display("pixel mismatch: expected rgb %02h%02h%02h col %0d row %0d",
                                 want_px.red, want_px.green, want_px.blue,
                                 want_px.column, want_px.row,
                                 " last %0d done %0d", want_px.last_of_run,
                                 want_px.image_done);
                        $display("                got      rgb %02h%02h%02h col %0d row %0d",
                                 seen_px.red, seen_px.green, seen_px.blue,
                                 seen_px.column, seen_px.row,
                                 " last %0d done %0d", seen_px.last_of_run,
                                 seen_px.image_done);
                    end
                end
            end
            hold_cycles = rx_idle ? int'($urandom_range(0, 8)) : 0;
        end
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: too long with no transaction on any port ends the run
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------
    initial begin
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        hold_cycles    = 0;
        errors         = 0;
        items_sent     = 0;
        pal_writes     = 0;
        data_bytes     = 0;
        cfg_writes     = 0;
        pixels_checked = 0;
        restore_defaults();

        // defaults after reset: 16 bpp 5-5-5, one by one, bottom-up
        add_byte(8'hFF);
        add_byte_px(8'h7F, 24'hFFFFFF, 0, 0, 1'b1);
        // padding to the 32-bit row end, then the image wraps
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h1F);
        add_byte_px(8'h00, 24'h0000FF, 0, 0, 1'b1);
        // palette extremes
        add_pal(8'd0, 8'hFF, 8'h00, 8'hFF);
        add_pal(8'd1, 8'h00, 8'hFF, 8'h00);
        add_pal(8'd255, 8'h80, 8'h7F, 8'h01);
        // 1 bpp, ten wide: second byte leaves six unused low bits
        add_cfg(CFG_PIXEL_FORMAT, 16'(FMT_1BPP));
        add_cfg(CFG_IMAGE_WIDTH, 16'd10);
        add_cfg(CFG_TOP_DOWN, 16'd1);
        add_byte(8'hA5);
        add_byte(8'hC0);
        // 8 bpp, oversized height clamps, bottom-up starts at the last row
        add_cfg(CFG_PIXEL_FORMAT, 16'(FMT_8BPP));
        add_cfg(CFG_IMAGE_WIDTH, 16'd1);
        add_cfg(CFG_IMAGE_HEIGHT, 16'd8191);
        add_cfg(CFG_TOP_DOWN, 16'd0);
        add_byte_px(8'hFF, 24'h807F01, 0, 4095, 1'b0);
        // 4 bpp, odd width: low nibble of the last byte is never looked up
        add_cfg(CFG_PIXEL_FORMAT, 16'(FMT_4BPP));
        add_cfg(CFG_IMAGE_WIDTH, 16'd3);
        add_cfg(CFG_IMAGE_HEIGHT, 16'd1);
        add_byte(8'h10);
        add_byte_px(8'h1F, 24'h00FF00, 2, 0, 1'b1);
        // 24 bpp with zero width acting as one
        add_cfg(CFG_PIXEL_FORMAT, 16'(FMT_24BPP));
        add_cfg(CFG_IMAGE_WIDTH, 16'd0);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte_px(8'h03, 24'h030201, 0, 0, 1'b1);
        // 32 bpp, fourth byte dropped
        add_cfg(CFG_PIXEL_FORMAT, 16'(FMT_32BPP));
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'h80);
        add_byte_px(8'h42, 24'h8000FF, 0, 0, 1'b1);
        // 16 bpp: six-bit red clamps, 5-6-5 green, empty blue mask
        add_cfg(CFG_PIXEL_FORMAT, 16'(FMT_16BPP));
        add_cfg(CFG_RED_MASK, 16'hFC00);
        add_cfg(CFG_GREEN_MASK, GREEN_MASK_565);
        add_cfg(CFG_BLUE_MASK, 16'h0000);
        add_byte(8'hFF);
        add_byte_px(8'hFF, 24'hFFFF00, 0, 0, 1'b1);
        // unknown format swallows bytes
        add_cfg(CFG_PIXEL_FORMAT, 16'd7);
        add_byte(8'hA5);

        // synchronous reset held, then released
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_script();
        while (items_sent < ITEM_TARGET) begin
            run_random_phase();
        end
        drain_outputs(1'b1);

        $display("covered %0d transactions in (%0d data bytes, %0d palette writes), %0d pixels out",
                 items_sent, data_bytes, pal_writes, pixels_checked);
        $display("over %0d register writes: all six formats, unknown format, clamped sizes",
                 cfg_writes, " and masks, both row orders, padding and image wrap");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bmp_rpu_pkg.sv
rtl/core/bmp_rpu_expand.sv
rtl/core/bmp_rpu_palette.sv
rtl/core/bmp_rpu_color.sv
rtl/core/bmp_row_pixel_unpacker.sv
rtl/core/bmp_rpu_chk.sv
verif/tb_bmp_row_pixel_unpacker.sv
